// ===== rtl/alle_pkg.sv =====
// shared types, constants and microcode table of the linked list engine
package alle_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int VALUE_BITS_DEF = 32;

  localparam int ANCHOR_W = 8;
  localparam int VALUE_W  = 32;
  localparam int CELL_W   = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD       = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // read address source
  typedef enum logic [1:0] {
    RA_ANCHOR = 2'd0,
    RA_FREE   = 2'd1,
    RA_ZERO   = 2'd2,
    RA_RDATA  = 2'd3
  } rd_src_t;

  // link write address
  typedef enum logic {
    WA_ANCHOR = 1'b0,
    WA_CUR    = 1'b1
  } wr_addr_t;

  // link write data
  typedef enum logic [1:0] {
    WD_AFTER = 2'd0,
    WD_CUR   = 2'd1,
    WD_RDATA = 2'd2,
    WD_FREE  = 2'd3
  } wr_data_t;

  typedef enum logic [1:0] {
    CUR_HOLD  = 2'd0,
    CUR_FREE  = 2'd1,
    CUR_RDATA = 2'd2
  } cur_ld_t;

  typedef enum logic [1:0] {
    FH_HOLD  = 2'd0,
    FH_RDATA = 2'd1,
    FH_CUR   = 2'd2
  } fh_ld_t;

  typedef enum logic [2:0] {
    C_NEVER   = 3'd0,
    C_FULL    = 3'd1,
    C_BAD_ANC = 3'd2,
    C_BAD_DEL = 3'd3,
    C_NONZERO = 3'd4,
    C_NOMATCH = 3'd5
  } cond_t;

  typedef enum logic {
    SQ_IDLE = 1'b0,
    SQ_RUN  = 1'b1
  } seq_state_t;

  typedef logic [3:0] step_t;

  // microcode addresses
  localparam step_t S_INS0   = 4'd0;
  localparam step_t S_INS1   = 4'd1;
  localparam step_t S_INS2   = 4'd2;
  localparam step_t S_INS3   = 4'd3;
  localparam step_t S_DEL0   = 4'd4;
  localparam step_t S_DEL1   = 4'd5;
  localparam step_t S_DEL2   = 4'd6;
  localparam step_t S_DEL3   = 4'd7;
  localparam step_t S_FND0   = 4'd8;
  localparam step_t S_FND1   = 4'd9;
  localparam step_t S_NFOUND = 4'd10;
  localparam step_t S_FND2   = 4'd11;
  localparam step_t S_FOUND  = 4'd12;
  localparam step_t S_FULL   = 4'd13;
  localparam step_t S_BAD    = 4'd14;

  typedef struct packed {
    logic     rd_en;
    rd_src_t  rd_src;
    logic     nw_en;
    wr_addr_t nw_addr;
    wr_data_t nw_data;
    logic     vw_en;
    logic     uw_en;
    logic     uw_data;
    cur_ld_t  cur_ld;
    fh_ld_t   fh_ld;
    logic     after_ld;
    cond_t    cond;
    step_t    target;
    logic     done;
    status_t  status;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic bad_anc;
    logic bad_del;
    logic nonzero;
    logic nomatch;
  } flags_t;

  function automatic step_t entry(logic [1:0] op);
    step_t s;
    case (op)
      OP_INSERT: s = S_INS0;
      OP_DELETE: s = S_DEL0;
      OP_FIND:   s = S_FND0;
      default:   s = S_BAD;
    endcase
    return s;
  endfunction

  function automatic ctl_t ucode(step_t a);
    ctl_t w;
    w = '0;
    case (a)
      S_INS0: begin
        w.rd_en  = 1'b1;
        w.rd_src = RA_ANCHOR;
        w.cond   = C_FULL;
        w.target = S_FULL;
      end
      S_INS1: begin
        w.rd_en    = 1'b1;
        w.rd_src   = RA_FREE;
        w.after_ld = 1'b1;
        w.cur_ld   = CUR_FREE;
        w.cond     = C_BAD_ANC;
        w.target   = S_BAD;
      end
      S_INS2: begin
        w.nw_en   = 1'b1;
        w.nw_addr = WA_CUR;
        w.nw_data = WD_AFTER;
        w.vw_en   = 1'b1;
        w.uw_en   = 1'b1;
        w.uw_data = 1'b1;
        w.fh_ld   = FH_RDATA;
      end
      S_INS3: begin
        w.nw_en   = 1'b1;
        w.nw_addr = WA_ANCHOR;
        w.nw_data = WD_CUR;
        w.done    = 1'b1;
        w.status  = ST_OK;
      end
      S_DEL0: begin
        w.rd_en  = 1'b1;
        w.rd_src = RA_ANCHOR;
      end
      S_DEL1: begin
        w.rd_en  = 1'b1;
        w.rd_src = RA_RDATA;
        w.cur_ld = CUR_RDATA;
        w.cond   = C_BAD_DEL;
        w.target = S_BAD;
      end
      S_DEL2: begin
        w.nw_en   = 1'b1;
        w.nw_addr = WA_ANCHOR;
        w.nw_data = WD_RDATA;
        w.uw_en   = 1'b1;
        w.uw_data = 1'b0;
      end
      S_DEL3: begin
        w.nw_en   = 1'b1;
        w.nw_addr = WA_CUR;
        w.nw_data = WD_FREE;
        w.fh_ld   = FH_CUR;
        w.done    = 1'b1;
        w.status  = ST_OK;
      end
      S_FND0: begin
        w.rd_en  = 1'b1;
        w.rd_src = RA_ZERO;
      end
      S_FND1: begin
        w.rd_en  = 1'b1;
        w.rd_src = RA_RDATA;
        w.cur_ld = CUR_RDATA;
        w.cond   = C_NONZERO;
        w.target = S_FND2;
      end
      S_NFOUND: begin
        w.done   = 1'b1;
        w.status = ST_NOT_FOUND;
      end
      S_FND2: begin
        w.cond   = C_NOMATCH;
        w.target = S_FND1;
      end
      S_FOUND: begin
        w.done   = 1'b1;
        w.status = ST_OK;
      end
      S_FULL: begin
        w.done   = 1'b1;
        w.status = ST_FULL;
      end
      default: begin
        w.done   = 1'b1;
        w.status = ST_BAD;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/array_linked_list_engine_core.sv =====
// top level of the array linked list engine with free list
// each op runs its microcode steps: insert stops early on a full list or a bad anchor, delete on
// a bad anchor or one with no successor; unknown ops report bad; find walks to a hit or list end
// one item at a time; the next input transfer can be taken once the result is registered
// find reads the cells one by one through the single read port of the cell memories
// after reset a clearing pass over all CAPACITY cells rebuilds the links before the first transfer
module array_linked_list_engine_core #(
  parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = alle_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // op[1:0], anchor[9:2], value[41:10], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // cell_res[7:0], status[9:8], zero fill
);

  alle_pkg::ctl_t    ctl;
  alle_pkg::flags_t  flags;
  alle_pkg::status_t status;
  logic                        clr_busy;
  logic                        busy;
  logic                        done;
  logic                        accept;
  logic                        stall;
  logic [alle_pkg::CELL_W-1:0] cur_cell;
  logic [alle_pkg::CELL_W-1:0] cell_res;

  assign s_tready = !busy && !clr_busy;
  assign accept   = s_tvalid && s_tready;
  assign stall    = m_tvalid && !m_tready;
  assign cell_res = (status == alle_pkg::ST_OK) ? cur_cell : '0;

  alle_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .op     (s_tdata[1:0]),
    .flags  (flags),
    .stall  (stall),
    .ctl    (ctl),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  alle_dpath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .anchor   (s_tdata[9:2]),
    .value    (s_tdata[41:10]),
    .ctl      (ctl),
    .flags    (flags),
    .clr_busy (clr_busy),
    .cur_cell (cur_cell)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {6'b0, status, cell_res};
    end
  end

endmodule

// ===== rtl/alle_dpath.sv =====
// datapath of the linked list engine: cell memories, pointers and clearing pass
module alle_dpath #(
  parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = alle_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [alle_pkg::ANCHOR_W-1:0] anchor,
  input  logic [alle_pkg::VALUE_W-1:0]  value,
  input  alle_pkg::ctl_t                ctl,
  output alle_pkg::flags_t              flags,
  output logic                          clr_busy,
  output logic [alle_pkg::CELL_W-1:0]   cur_cell
);

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
  localparam logic [16:0] CAP_W = 17'(CAPACITY);

  logic [IW-1:0]         nxt_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic                  use_mem [CAPACITY];

  logic [alle_pkg::ANCHOR_W-1:0] anchor_r;
  logic [VALUE_BITS-1:0]         val_r;
  logic [IW-1:0]                 cur;
  logic [IW-1:0]                 fh;
  logic [IW-1:0]                 after;
  logic [IW-1:0]                 nxt_rd;
  logic [VALUE_BITS-1:0]         val_rd;
  logic                          use_rd;
  logic [IW-1:0]                 clr_cnt;

  logic [IW-1:0]   aidx;
  logic [IW-1:0]   ra;
  logic            nw_en;
  logic [IW-1:0]   nw_a;
  logic [IW-1:0]   nw_d;
  logic            uw_en;
  logic [IW-1:0]   uw_a;
  logic            uw_d;
  logic            anchor_ok;
  logic [63:0]     vext;

  assign aidx = IW'(anchor_r);
  assign vext = 64'($signed(value));
  assign anchor_ok = (17'(anchor_r) < CAP_W) && use_rd;

  always_comb begin
    case (ctl.rd_src)
      alle_pkg::RA_ANCHOR: ra = aidx;
      alle_pkg::RA_FREE:   ra = fh;
      alle_pkg::RA_ZERO:   ra = '0;
      alle_pkg::RA_RDATA:  ra = nxt_rd;
      default:             ra = '0;
    endcase
  end

  always_comb begin
    if (clr_busy) begin
      nw_en = 1'b1;
      nw_a  = clr_cnt;
      nw_d  = (clr_cnt == LAST || clr_cnt == '0) ? '0 : IW'(clr_cnt + 1'b1);
      uw_en = 1'b1;
      uw_a  = clr_cnt;
      uw_d  = (clr_cnt == '0);
    end else begin
      nw_en = ctl.nw_en;
      nw_a  = (ctl.nw_addr == alle_pkg::WA_CUR) ? cur : aidx;
      case (ctl.nw_data)
        alle_pkg::WD_AFTER: nw_d = after;
        alle_pkg::WD_CUR:   nw_d = cur;
        alle_pkg::WD_RDATA: nw_d = nxt_rd;
        alle_pkg::WD_FREE:  nw_d = fh;
        default:            nw_d = '0;
      endcase
      uw_en = ctl.uw_en;
      uw_a  = cur;
      uw_d  = ctl.uw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      nxt_rd <= nxt_mem[ra];
      val_rd <= val_mem[ra];
      use_rd <= use_mem[ra];
    end
    if (nw_en) begin
      nxt_mem[nw_a] <= nw_d;
    end
    if (uw_en) begin
      use_mem[uw_a] <= uw_d;
    end
    if (ctl.vw_en) begin
      val_mem[cur] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      anchor_r <= anchor;
      val_r    <= VALUE_BITS'(vext);
    end
    if (ctl.after_ld) begin
      after <= nxt_rd;
    end
    case (ctl.cur_ld)
      alle_pkg::CUR_FREE:  cur <= fh;
      alle_pkg::CUR_RDATA: cur <= nxt_rd;
      default:             cur <= cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fh       <= IW'(1);
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else begin
      case (ctl.fh_ld)
        alle_pkg::FH_RDATA: fh <= nxt_rd;
        alle_pkg::FH_CUR:   fh <= cur;
        default:            fh <= fh;
      endcase
      if (clr_busy) begin
        clr_cnt <= IW'(clr_cnt + 1'b1);
        if (clr_cnt == LAST) begin
          clr_busy <= 1'b0;
        end
      end
    end
  end

  assign flags.full    = (fh == '0);
  assign flags.bad_anc = !anchor_ok;
  assign flags.bad_del = !anchor_ok || (nxt_rd == '0);
  assign flags.nonzero = (nxt_rd != '0);
  assign flags.nomatch = (val_rd != val_r);

  assign cur_cell = alle_pkg::CELL_W'(cur);

endmodule

// ===== rtl/alle_useq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
module alle_useq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       op,
  input  alle_pkg::flags_t flags,
  input  logic             stall,
  output alle_pkg::ctl_t   ctl,
  output logic             busy,
  output logic             done,
  output alle_pkg::status_t status
);

  alle_pkg::seq_state_t state, state_next;
  alle_pkg::step_t      step, step_next;
  alle_pkg::ctl_t       word;
  logic                 taken;

  assign word   = alle_pkg::ucode(step);
  assign status = word.status;
  assign busy   = (state == alle_pkg::SQ_RUN);

  always_comb begin
    case (word.cond)
      alle_pkg::C_FULL:    taken = flags.full;
      alle_pkg::C_BAD_ANC: taken = flags.bad_anc;
      alle_pkg::C_BAD_DEL: taken = flags.bad_del;
      alle_pkg::C_NONZERO: taken = flags.nonzero;
      alle_pkg::C_NOMATCH: taken = flags.nomatch;
      default:             taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alle_pkg::SQ_IDLE;
      step  <= alle_pkg::S_BAD;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    ctl        = '0;
    done       = 1'b0;
    case (state)
      alle_pkg::SQ_IDLE: begin
        if (start) begin
          state_next = alle_pkg::SQ_RUN;
          step_next  = alle_pkg::entry(op);
        end
      end
      alle_pkg::SQ_RUN: begin
        if (word.done) begin
          if (!stall) begin
            ctl        = word;
            done       = 1'b1;
            state_next = alle_pkg::SQ_IDLE;
          end
        end else begin
          ctl = word;
          if (taken) begin
            step_next = word.target;
          end else begin
            step_next = 4'(step + 4'd1);
          end
        end
      end
      default: begin
        state_next = alle_pkg::SQ_IDLE;
      end
    endcase
  end

endmodule

// ===== dv/array_linked_list_engine_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the array linked list engine core
module array_linked_list_engine_core_tb;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  anchor;
    logic [31:0] value;
  } list_cmd_t;

  typedef struct {
    logic [7:0]        cell_idx;
    alle_pkg::status_t status;
  } list_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  list_cmd_t    cmd_q[$];
  list_cmd_t    cmd_on_bus;
  list_answer_t answer_q[$];

  logic [7:0]  link_fwd[256];
  logic [7:0]  link_back[256];
  logic        cell_busy[256];
  logic [31:0] cell_data[256];
  logic [7:0]  free_top;

  int send_idle_pct = 29;
  int recv_idle_pct = 71;
  int fails = 0;

  array_linked_list_engine_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  function automatic list_answer_t apply_list_op(list_cmd_t c);
    list_answer_t a;
    logic [7:0] cur;
    logic [7:0] after;
    int steps;
    a.cell_idx = '0;
    a.status = alle_pkg::ST_BAD;
    case (c.op)
      alle_pkg::OP_INSERT: begin
        if (free_top == 8'd0) begin
          a.status = alle_pkg::ST_FULL;
        end else if (cell_busy[c.anchor]) begin
          cur = free_top;
          after = link_fwd[c.anchor];
          free_top = link_fwd[cur];
          cell_data[cur] = c.value;
          cell_busy[cur] = 1'b1;
          link_fwd[cur] = after;
          link_back[cur] = c.anchor;
          link_back[after] = cur;
          link_fwd[c.anchor] = cur;
          a.cell_idx = cur;
          a.status = alle_pkg::ST_OK;
        end
      end
      alle_pkg::OP_DELETE: begin
        if (cell_busy[c.anchor] && link_fwd[c.anchor] != 8'd0) begin
          cur = link_fwd[c.anchor];
          after = link_fwd[cur];
          link_fwd[c.anchor] = after;
          link_back[after] = c.anchor;
          cell_busy[cur] = 1'b0;
          link_back[cur] = 8'd0;
          link_fwd[cur] = free_top;
          free_top = cur;
          a.cell_idx = cur;
          a.status = alle_pkg::ST_OK;
        end
      end
      alle_pkg::OP_FIND: begin
        a.status = alle_pkg::ST_NOT_FOUND;
        cur = link_fwd[0];
        steps = 0;
        while (cur != 8'd0 && steps < 256) begin
          if (cell_data[cur] == c.value) begin
            a.cell_idx = cur;
            a.status = alle_pkg::ST_OK;
            break;
          end
          cur = link_fwd[cur];
          steps++;
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) answer_q.push_back(apply_list_op(cmd_on_bus));
      if (!s_tvalid || s_tready) begin
        if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_on_bus = cmd_q.pop_front();
          s_tdata <= {6'b0, cmd_on_bus.value, cmd_on_bus.anchor, cmd_on_bus.op};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    list_answer_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result transfer: cell_res %0d status %0d",
                 m_tdata[7:0], m_tdata[9:8]);
          fails++;
        end else begin
          want = answer_q.pop_front();
          if (m_tdata[7:0] !== want.cell_idx) begin
            $error("cell_res: expected %0d, got %0d", want.cell_idx, m_tdata[7:0]);
            fails++;
          end
          if (m_tdata[9:8] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[9:8]);
            fails++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic queue_cmd(logic [1:0] op, logic [7:0] anchor, logic [31:0] value);
    list_cmd_t c;
    c.op = op;
    c.anchor = anchor;
    c.value = value;
    cmd_q.push_back(c);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (cmd_q.size() != 0 || s_tvalid || answer_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_live_cell();
    logic [7:0] start;
    logic [7:0] idx;
    start = 8'($urandom_range(0, 255));
    for (int i = 0; i < 256; i++) begin
      idx = start + i[7:0];
      if (cell_busy[idx]) return idx;
    end
    return 8'd0;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4, 5: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic make_cmd(mix_t mix);
    int r;
    int s;
    logic [1:0] op;
    logic [7:0] anchor;
    logic [7:0] hit;
    logic [31:0] value;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      op = OP_UNKNOWN;
    end else begin
      case (mix)
        MIX_FILL:  op = (r < 82) ? alle_pkg::OP_INSERT :
                        (r < 87) ? alle_pkg::OP_DELETE : alle_pkg::OP_FIND;
        MIX_DRAIN: op = (r < 12) ? alle_pkg::OP_INSERT :
                        (r < 82) ? alle_pkg::OP_DELETE : alle_pkg::OP_FIND;
        default:   op = (r < 40) ? alle_pkg::OP_INSERT :
                        (r < 70) ? alle_pkg::OP_DELETE : alle_pkg::OP_FIND;
      endcase
    end
    s = $urandom_range(0, 99);
    if (s < 70) anchor = pick_live_cell();
    else if (s < 85) anchor = 8'd0;
    else anchor = 8'($urandom_range(0, 255));
    value = $urandom;
    if (op == alle_pkg::OP_INSERT) begin
      value = pick_value();
    end else if (op == alle_pkg::OP_FIND) begin
      hit = pick_live_cell();
      if (hit != 8'd0 && $urandom_range(0, 99) < 60) value = cell_data[hit];
      else value = pick_value();
    end
    queue_cmd(op, anchor, value);
  endtask

  initial begin
    mix_t mix;
    int n;
    link_fwd[0] = 8'd0;
    for (int i = 1; i < 256; i++) link_fwd[i] = (i < 255) ? 8'(i + 1) : 8'd0;
    for (int i = 0; i < 256; i++) begin
      link_back[i] = 8'd0;
      cell_busy[i] = (i == 0);
      cell_data[i] = '0;
    end
    free_top = 8'd1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, value extremes, bad anchors, unknown op, reuse of freed cells
    queue_cmd(alle_pkg::OP_FIND,   8'd0,   32'h0);
    queue_cmd(alle_pkg::OP_DELETE, 8'd0,   32'h0);
    queue_cmd(alle_pkg::OP_INSERT, 8'd0,   32'h7fff_ffff);
    queue_cmd(alle_pkg::OP_INSERT, 8'd1,   32'h8000_0000);
    queue_cmd(alle_pkg::OP_INSERT, 8'd0,   32'hffff_ffff);
    queue_cmd(alle_pkg::OP_INSERT, 8'd2,   32'h0);
    queue_cmd(alle_pkg::OP_INSERT, 8'd255, 32'h1234_5678);
    queue_cmd(alle_pkg::OP_INSERT, 8'd200, 32'h1);
    queue_cmd(alle_pkg::OP_DELETE, 8'd255, 32'hffff_ffff);
    queue_cmd(OP_UNKNOWN,          8'd255, 32'hffff_ffff);
    queue_cmd(OP_UNKNOWN,          8'd0,   32'h0);
    queue_cmd(alle_pkg::OP_FIND,   8'd255, 32'h8000_0000);
    queue_cmd(alle_pkg::OP_FIND,   8'd0,   32'hffff_ffff);
    queue_cmd(alle_pkg::OP_FIND,   8'd0,   32'h0);
    queue_cmd(alle_pkg::OP_FIND,   8'd0,   32'h7fff_ffff);
    queue_cmd(alle_pkg::OP_FIND,   8'd0,   32'd12345);
    queue_cmd(alle_pkg::OP_DELETE, 8'd4,   32'h0);
    queue_cmd(alle_pkg::OP_DELETE, 8'd2,   32'h0);
    queue_cmd(alle_pkg::OP_FIND,   8'd0,   32'h0);
    queue_cmd(alle_pkg::OP_INSERT, 8'd4,   32'h0);
    queue_cmd(alle_pkg::OP_DELETE, 8'd0,   32'h0);
    queue_cmd(alle_pkg::OP_INSERT, 8'd0,   32'h5555_5555);
    queue_cmd(alle_pkg::OP_INSERT, 8'd3,   32'haaaa_aaaa);
    queue_cmd(alle_pkg::OP_DELETE, 8'd1,   32'h0);
    queue_cmd(alle_pkg::OP_FIND,   8'd0,   32'haaaa_aaaa);
    wait_quiet();

    // random: grow to full, drain, then an even mix; each batch of 25 ends once its commands and results are drained
    n = 0;
    while (n < 1500) begin
      if (n < 500) begin
        send_idle_pct = 29;
        recv_idle_pct = 71;
      end else if (n < 1000) begin
        send_idle_pct = 71;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n < 450) mix = MIX_FILL;
      else if (n < 800) mix = MIX_DRAIN;
      else mix = MIX_EVEN;
      for (int k = 0; k < 25; k++) make_cmd(mix);
      n += 25;
      wait_quiet();
    end

    repeat (600) @(posedge clk);
    if (fails == 0 && answer_q.size() == 0) begin
      $display("array_linked_list_engine_core_tb: done, clean");
    end else begin
      $display("array_linked_list_engine_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("array_linked_list_engine_core_tb: done, errors");
    $finish;
  end

endmodule

// ===== array_linked_list_engine_core.f =====
rtl/alle_pkg.sv
rtl/alle_dpath.sv
rtl/alle_useq.sv
rtl/array_linked_list_engine_core.sv
dv/array_linked_list_engine_core_tb.sv
